>>> rtl/bpa_pkg.sv
// bpa_pkg: shared codes and fixed field widths of the buddy page allocator
// no dependencies
`default_nettype none
package bpa_pkg;
	localparam int PAGE_W   = 12;
	localparam int ORDER_W  = 4;
	localparam int STATUS_W = 2;
	localparam int OW       = 5;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ORD  = 2'd2;
endpackage
`default_nettype wire

>>> rtl/buddy_page_allocator.sv
// buddy_page_allocator: top level, sequencer over free lists and link memories
// depends on bpa_pkg, bpa_link_ram, bpa_pair_ram
//
// channel   | signals                            | handshake
// request   | func, order, page_number           | taken when start && !busy
// result    | page_number_res, status            | one cycle, marked by done
//
// one request gives one result; a bad order or out-of-range free is answered
// straight from idle; otherwise each order searched costs one search step, each
// split the steps pair-bit read, pair-bit write and append, and each merge the
// steps link read, link write, step up, pair-bit read and pair-bit write
// after reset busy stays high while the PAGES+ORDERS pair bits clear
// the receiver cannot stall; done pulses for exactly one cycle
`default_nettype none
module buddy_page_allocator
	import bpa_pkg::*;
#(
	parameter int PAGES  = 4096,
	parameter int ORDERS = 15
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                func,
	input  wire logic [ORDER_W-1:0]  order,
	input  wire logic [PAGE_W-1:0]   page_number,
	output logic                     done,
	output logic [PAGE_W-1:0]        page_number_res,
	output logic [STATUS_W-1:0]      status
);
	localparam int PAIR_STORE = PAGES + ORDERS;
	localparam int AW0 = $clog2(PAGES + (1 << ORDERS)) + 1;
	localparam int AW  = (AW0 > PAGE_W + 1) ? AW0 : PAGE_W + 1;  // page arithmetic width
	localparam int CW  = AW + 1;                                 // slot arithmetic width
	localparam int LW  = $clog2(PAGES);
	localparam int SW  = $clog2(PAIR_STORE);
	localparam int OIW = $clog2(ORDERS);

	typedef enum logic [3:0] {
		S_IDLE, S_SEARCH, S_URD, S_UWR, S_TRD, S_TWR, S_SPLIT, S_MERGE, S_APPEND
	} state_t;

	state_t             state_q;
	logic               func_q;
	logic [OW-1:0]      ord_q;      // requested order
	logic [OW-1:0]      o_q;        // current order
	logic [AW-1:0]      p_q;        // current block page
	logic [AW-1:0]      u_q;        // node to unlink
	logic               uoob_q;
	logic               tv_q;       // pair toggle is in range
	logic               split_q;
	logic               done_q;
	logic [AW-1:0]      res_q;
	logic [STATUS_W-1:0] status_q;

	// free lists: head/tail payload, valid bits reset
	logic [AW-1:0]      head_q [ORDERS];
	logic [AW-1:0]      tail_q [ORDERS];
	logic [ORDERS-1:0]  valid_q;

	// link memories
	logic [AW-1:0]      nx_rd, pv_rd;
	logic               nx_we, pv_we;
	logic [AW-1:0]      nx_wa, nx_wd, pv_wa, pv_wd;

	// pair bits
	logic               pair_rd, pair_ready, pair_we;

	// shared address unit
	logic [OW-1:0]      o_inc;
	logic [CW-1:0]      slot;
	logic [AW-1:0]      bit_o;
	logic [AW-1:0]      buddy;
	logic [OIW-1:0]     oi;
	logic [OW-1:0]      ao;
	logic [OIW-1:0]     aoi;
	logic [AW-1:0]      nx_v, pv_v;
	logic               old_bit;
	logic [OW-1:0]      order_x;
	logic [AW-1:0]      page_x;

	assign order_x = OW'(order);
	assign page_x  = AW'(page_number);
	assign o_inc   = o_q + OW'(1);
	assign oi      = o_q[OIW-1:0];
	assign bit_o   = AW'(1) << o_q;
	assign buddy   = p_q ^ bit_o;
	// slot = PAGES - (PAGES >> o) + o + (p >> (o + 1))
	assign slot    = CW'(PAGES) - (CW'(PAGES) >> o_q) + CW'(o_q) + (CW'(p_q) >> o_inc);
	assign nx_v    = uoob_q ? '0 : nx_rd;
	assign pv_v    = uoob_q ? '0 : pv_rd;
	assign old_bit = tv_q & pair_rd;
	assign pair_we = (state_q == S_TWR) && tv_q;
	// append order: one below current while splitting
	assign ao      = (state_q == S_SPLIT) ? o_q - OW'(1) : o_q;
	assign aoi     = ao[OIW-1:0];

	// link write selection for unlink and append
	always_comb begin
		nx_we = 1'b0;
		nx_wa = '0;
		nx_wd = '0;
		pv_we = 1'b0;
		pv_wa = '0;
		pv_wd = '0;
		case (state_q)
			S_UWR: begin
				if (!(valid_q[oi] && head_q[oi] == u_q)) begin
					nx_we = 1'b1;
					nx_wa = pv_v;
					nx_wd = nx_v;
					if (!(valid_q[oi] && tail_q[oi] == u_q)) begin
						pv_we = 1'b1;
						pv_wa = nx_v;
						pv_wd = pv_v;
					end
				end
			end
			S_SPLIT, S_APPEND: begin
				if ((state_q == S_APPEND || o_q > ord_q) && valid_q[aoi]) begin
					nx_we = 1'b1;
					nx_wa = tail_q[aoi];
					nx_wd = p_q;
					pv_we = 1'b1;
					pv_wa = p_q;
					pv_wd = tail_q[aoi];
				end
			end
			default: begin
			end
		endcase
	end

	bpa_link_ram #(.DEPTH(PAGES), .W(AW)) u_next (
		.clk   (clk),
		.we    (nx_we && nx_wa < AW'(PAGES)),
		.waddr (nx_wa[LW-1:0]),
		.wdata (nx_wd),
		.raddr (u_q[LW-1:0]),
		.rdata (nx_rd)
	);

	bpa_link_ram #(.DEPTH(PAGES), .W(AW)) u_prev (
		.clk   (clk),
		.we    (pv_we && pv_wa < AW'(PAGES)),
		.waddr (pv_wa[LW-1:0]),
		.wdata (pv_wd),
		.raddr (u_q[LW-1:0]),
		.rdata (pv_rd)
	);

	bpa_pair_ram #(.DEPTH(PAIR_STORE)) u_pair (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (slot[SW-1:0]),
		.we     (pair_we),
		.waddr  (slot[SW-1:0]),
		.wdata  (!pair_rd),
		.rdata  (pair_rd),
		.ready  (pair_ready)
	);

	// head/tail payload updates
	always_ff @(posedge clk) begin
		case (state_q)
			S_UWR: begin
				if (valid_q[oi] && head_q[oi] == u_q) begin
					head_q[oi] <= nx_v;
				end else if (valid_q[oi] && tail_q[oi] == u_q) begin
					tail_q[oi] <= pv_v;
				end
			end
			S_SPLIT, S_APPEND: begin
				if (state_q == S_APPEND || o_q > ord_q) begin
					if (!valid_q[aoi]) begin
						head_q[aoi] <= p_q;
					end
					tail_q[aoi] <= p_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= '0;
			done_q   <= 1'b0;
			func_q   <= FUNC_ALLOC;
			ord_q    <= '0;
			o_q      <= '0;
			p_q      <= '0;
			u_q      <= '0;
			uoob_q   <= 1'b0;
			tv_q     <= 1'b0;
			split_q  <= 1'b0;
			res_q    <= '0;
			status_q <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && pair_ready) begin
						func_q <= func;
						ord_q  <= order_x;
						o_q    <= order_x;
						res_q  <= '0;
						if (order_x >= OW'(ORDERS)) begin
							done_q   <= 1'b1;
							status_q <= ST_BAD_ORD;
						end else if (func == FUNC_ALLOC) begin
							split_q <= 1'b0;
							state_q <= S_SEARCH;
						end else if (page_x >= AW'(PAGES)) begin
							// page beyond the pool: ignored
							done_q   <= 1'b1;
							status_q <= ST_OK;
						end else begin
							p_q     <= page_x & ~((AW'(1) << order_x) - AW'(1));
							state_q <= S_MERGE;
						end
					end
				end
				S_SEARCH: begin
					if (o_q == OW'(ORDERS)) begin
						done_q   <= 1'b1;
						status_q <= ST_NO_BLOCK;
						state_q  <= S_IDLE;
					end else if (valid_q[oi]) begin
						u_q     <= head_q[oi];
						p_q     <= head_q[oi];
						state_q <= S_URD;
					end else begin
						o_q <= o_inc;
					end
				end
				S_URD: begin
					uoob_q  <= u_q >= AW'(PAGES);
					state_q <= S_UWR;
				end
				S_UWR: begin
					if (valid_q[oi] && head_q[oi] == u_q && tail_q[oi] == u_q) begin
						valid_q[oi] <= 1'b0;
					end
					if (func_q == FUNC_ALLOC) begin
						state_q <= S_TRD;
					end else begin
						// merged with buddy: move up one order
						p_q     <= p_q & ~bit_o;
						o_q     <= o_inc;
						state_q <= S_MERGE;
					end
				end
				S_TRD: begin
					tv_q    <= (o_inc < OW'(ORDERS)) && (slot < CW'(PAIR_STORE));
					state_q <= S_TWR;
				end
				S_TWR: begin
					if (func_q == FUNC_ALLOC) begin
						if (split_q) begin
							p_q <= p_q + bit_o;
						end
						state_q <= S_SPLIT;
					end else if (!old_bit || buddy >= AW'(PAGES)) begin
						state_q <= S_APPEND;
					end else begin
						u_q     <= buddy;
						state_q <= S_URD;
					end
				end
				S_SPLIT: begin
					if (o_q > ord_q) begin
						valid_q[aoi] <= 1'b1;
						o_q          <= ao;
						split_q      <= 1'b1;
						state_q      <= S_TRD;
					end else begin
						done_q   <= 1'b1;
						res_q    <= p_q;
						status_q <= ST_OK;
						state_q  <= S_IDLE;
					end
				end
				S_MERGE: begin
					state_q <= (o_inc < OW'(ORDERS)) ? S_TRD : S_APPEND;
				end
				S_APPEND: begin
					valid_q[aoi] <= 1'b1;
					done_q       <= 1'b1;
					status_q     <= ST_OK;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE) || !pair_ready;
	assign done            = done_q;
	assign page_number_res = res_q[PAGE_W-1:0];
	assign status          = status_q;
endmodule
`default_nettype wire

>>> rtl/bpa_link_ram.sv
// bpa_link_ram: one write port, one registered read port link memory
// no dependencies
`default_nettype none
module bpa_link_ram #(
	parameter int DEPTH = 4096,
	parameter int W     = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/bpa_pair_ram.sv
// bpa_pair_ram: buddy pair toggle bits with a clearing sweep after reset
// no dependencies
`default_nettype none
module bpa_pair_ram #(
	parameter int DEPTH = 4111
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic                     wdata,
	output logic                          rdata,
	output logic                          ready
);
	localparam int AW = $clog2(DEPTH);

	logic          mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic          clr_on_q;

	// sweep one entry per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			clr_on_q <= 1'b1;
		end else if (clr_on_q) begin
			if (clr_q == AW'(DEPTH - 1)) begin
				clr_on_q <= 1'b0;
			end
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_on_q) begin
			mem[clr_q] <= 1'b0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	assign ready = !clr_on_q;
endmodule
`default_nettype wire

>>> tb/bpa_checker.sv
// bpa_checker: watches the request and result channels of the buddy page allocator,
// predicts each result from its own copy of the free lists, and counts mismatches
// depends on bpa_pkg
`default_nettype none
module bpa_checker
	import bpa_pkg::*;
#(
	parameter int PAGES  = 4096,
	parameter int ORDERS = 15
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire logic                func,
	input  wire logic [ORDER_W-1:0]  order,
	input  wire logic [PAGE_W-1:0]   page_number,
	input  wire logic                done,
	input  wire logic [PAGE_W-1:0]   page_number_res,
	input  wire logic [STATUS_W-1:0] status,
	output int                       errors,
	output int                       backlog,
	output int                       n_granted,
	output int                       n_exhausted,
	output int                       n_bad_order,
	output int                       n_freed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAIR_SLOTS = PAGES + ORDERS;

	typedef struct packed {
		logic [PAGE_W-1:0]   page;
		logic [STATUS_W-1:0] st;
	} grant_t;

	grant_t      grant_q[$];
	bit          pair_bit[PAIR_SLOTS];
	int unsigned fwd[PAGES];
	int unsigned bwd[PAGES];
	int unsigned head[ORDERS];
	int unsigned tail[ORDERS];
	bit          nonempty[ORDERS];

	function automatic int unsigned link_rd(bit is_fwd, int unsigned p);
		if (p >= PAGES) return 0;
		return is_fwd ? fwd[p] : bwd[p];
	endfunction

	function automatic void link_wr(bit is_fwd, int unsigned p, int unsigned v);
		if (p >= PAGES) return;
		if (is_fwd) fwd[p] = v;
		else bwd[p] = v;
	endfunction

	function automatic bit flip_pair(int unsigned o, int unsigned p);
		int unsigned slot;
		bit was;
		if (o + 1 >= ORDERS) return 1'b0;
		slot = PAGES - (PAGES >> o) + o + (p >> (o + 1));
		if (slot >= PAIR_SLOTS) return 1'b0;
		was = pair_bit[slot];
		pair_bit[slot] = !was;
		return was;
	endfunction

	function automatic void push_tail(int unsigned o, int unsigned p);
		if (!nonempty[o]) begin
			head[o] = p;
			nonempty[o] = 1'b1;
		end else begin
			link_wr(1'b1, tail[o], p);
			link_wr(1'b0, p, tail[o]);
		end
		tail[o] = p;
	endfunction

	function automatic void take_out(int unsigned o, int unsigned p);
		int unsigned nx, pv;
		nx = link_rd(1'b1, p);
		pv = link_rd(1'b0, p);
		if (nonempty[o] && head[o] == p) begin
			if (tail[o] == p) nonempty[o] = 1'b0;
			else head[o] = nx;
			return;
		end
		link_wr(1'b1, pv, nx);
		if (nonempty[o] && tail[o] == p) tail[o] = pv;
		else link_wr(1'b0, nx, pv);
	endfunction

	function automatic grant_t serve(logic f, int unsigned ord, int unsigned pg);
		grant_t g;
		int unsigned o, p, buddy;
		g = '0;
		g.st = ST_OK;
		if (ord >= ORDERS) begin
			g.st = ST_BAD_ORD;
		end else if (f == FUNC_ALLOC) begin
			o = ord;
			while (o < ORDERS && !nonempty[o]) o++;
			if (o >= ORDERS) begin
				g.st = ST_NO_BLOCK;
			end else begin
				p = head[o];
				take_out(o, p);
				void'(flip_pair(o, p));
				while (o > ord) begin
					o--;
					push_tail(o, p);
					void'(flip_pair(o, p));
					p += 1 << o;
				end
				g.page = p[PAGE_W-1:0];
			end
		end else if (pg < PAGES) begin
			o = ord;
			p = pg & ~((1 << o) - 1);
			while (o + 1 < ORDERS) begin
				if (!flip_pair(o, p)) break;
				buddy = p ^ (1 << o);
				if (buddy >= PAGES) break;
				take_out(o, buddy);
				p &= ~(1 << o);
				o++;
			end
			push_tail(o, p);
		end
		return g;
	endfunction

	assign backlog = grant_q.size();

	always @(posedge clk or negedge arst_n) begin
		grant_t g, want;
		if (!arst_n) begin
			grant_q.delete();
			foreach (pair_bit[i]) pair_bit[i] = 1'b0;
			foreach (nonempty[i]) nonempty[i] = 1'b0;
			errors = 0;
			n_granted = 0;
			n_exhausted = 0;
			n_bad_order = 0;
			n_freed = 0;
		end else begin
			if (start && !busy) begin
				g = serve(func, order, page_number);
				grant_q.push_back(g);
				if (g.st == ST_BAD_ORD) n_bad_order++;
				else if (g.st == ST_NO_BLOCK) n_exhausted++;
				else if (func == FUNC_ALLOC) n_granted++;
				else n_freed++;
			end
			if (done) begin
				if (grant_q.size() == 0) begin
					if (errors < 10)
						$display("%t unexpected result page %0d status %0d",
							$realtime, page_number_res, status);
					errors++;
				end else begin
					want = grant_q.pop_front();
					if (want.page !== page_number_res || want.st !== status) begin
						if (errors < 10)
							$display("%t mismatch: page exp %0d got %0d, status exp %0d got %0d",
								$realtime, want.page, page_number_res, want.st, status);
						errors++;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> tb/buddy_page_allocator_test.sv
// buddy_page_allocator_test: stimulus and verdict for the buddy page allocator
// depends on bpa_pkg, buddy_page_allocator and bpa_checker
// the checker predicts and compares; this module only makes requests
`default_nettype none
module buddy_page_allocator_test;
	import bpa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGES      = 4096;
	localparam int ORDERS     = 15;
	localparam int RAND_REQS  = 1530;
	// first order value the block rejects
	localparam logic [ORDER_W-1:0] ORDER_OOR = ORDER_W'(ORDERS);

	typedef struct {
		logic [PAGE_W-1:0]  page;
		logic [ORDER_W-1:0] ord;
	} block_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                func;
	logic [ORDER_W-1:0]  order;
	logic [PAGE_W-1:0]   page_number;
	logic                done;
	logic [PAGE_W-1:0]   page_number_res;
	logic [STATUS_W-1:0] status;

	int errors, backlog, n_granted, n_exhausted, n_bad_order, n_freed;

	// blocks currently held by the "software" side, plus in-flight requests
	block_t held[$];
	logic   inflight_func[$];
	logic [ORDER_W-1:0] inflight_ord[$];
	bit     quiet;

	buddy_page_allocator #(.PAGES(PAGES), .ORDERS(ORDERS)) dut (.*);

	bpa_checker #(.PAGES(PAGES), .ORDERS(ORDERS)) chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("timeout with %0d requests outstanding", backlog);
		$display("[FAIL] regression broken");
		$finish;
	end

	// remember every granted block so frees only ever return owned memory
	always @(posedge clk) begin
		logic f;
		logic [ORDER_W-1:0] o;
		if (start && !busy) begin
			inflight_func.push_back(func);
			inflight_ord.push_back(order);
		end
		if (done && inflight_func.size() > 0) begin
			f = inflight_func.pop_front();
			o = inflight_ord.pop_front();
			if (f == FUNC_ALLOC && status == ST_OK)
				held.push_back('{page: page_number_res, ord: o});
		end
	end

	// one request: optional random gap, then hold start until the block takes it
	task automatic issue(logic f, logic [ORDER_W-1:0] o, logic [PAGE_W-1:0] p);
		if (!quiet && $urandom_range(99) < 16) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 50);
		end
		start <= 1'b1;
		func <= f;
		order <= o;
		page_number <= p;
		do @(posedge clk); while (busy);
	endtask

	// stop sending until every result has come back
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (backlog != 0 || inflight_func.size() != 0) @(posedge clk);
	endtask

	// hand back a random owned block, with junk in the bits below its alignment
	task automatic give_back();
		int k;
		block_t b;
		logic [PAGE_W-1:0] junk;
		k = $urandom_range(held.size() - 1);
		b = held[k];
		held.delete(k);
		junk = PAGE_W'($urandom) & PAGE_W'((1 << b.ord) - 1);
		issue(FUNC_FREE, b.ord, b.page | junk);
	endtask

	initial begin
		int r;
		logic [ORDER_W-1:0] o;
		quiet = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_ALLOC;
		order = '0;
		page_number = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty pool and out-of-range orders
		issue(FUNC_ALLOC, '0, 12'hfff);
		issue(FUNC_ALLOC, ORDER_W'(ORDERS - 1), '0);
		issue(FUNC_ALLOC, ORDER_OOR, '0);
		issue(FUNC_FREE, ORDER_OOR, 12'hfff);
		issue(FUNC_FREE, 4'hf, 12'hfff);
		// seed the whole pool as one block, then split it all the way down
		issue(FUNC_FREE, ORDER_W'(12), '0);
		issue(FUNC_ALLOC, '0, '0);
		issue(FUNC_ALLOC, ORDER_W'(12), '0);
		issue(FUNC_ALLOC, ORDER_W'(13), '0);
		for (int i = 1; i <= 11; i += 2) issue(FUNC_ALLOC, ORDER_W'(i), 12'hfff);
		settle();
		// return everything so the pool merges back into one whole-pool block
		while (held.size() > 0) give_back();
		settle();
		issue(FUNC_ALLOC, ORDER_W'(12), '0);
		issue(FUNC_ALLOC, '0, '0);
		settle();
		while (held.size() > 0) give_back();

		// random mix of allocations and owned frees, with a quiet stretch
		for (int n = 0; n < RAND_REQS; n++) begin
			quiet = (n >= 600 && n < 850);
			if (n == 1100) settle();
			r = $urandom_range(99);
			if (r < 4) begin
				issue(1'($urandom_range(1)), ORDER_OOR, PAGE_W'($urandom));
			end else if (held.size() > 0 && (r < 48 || held.size() > 60)) begin
				give_back();
			end else begin
				o = ($urandom_range(9) < 8) ? ORDER_W'($urandom_range(3))
					: ORDER_W'($urandom_range(ORDERS - 1));
				issue(FUNC_ALLOC, o, PAGE_W'($urandom));
			end
			// wait for a result before a free if nothing is owned yet
			if (held.size() == 0 && $urandom_range(3) == 0) settle();
		end
		settle();
		repeat (120) @(posedge clk);

		$display("covered %0d grants, %0d frees, %0d exhausted pools, %0d bad orders",
			n_granted, n_freed, n_exhausted, n_bad_order);
		$display("pool was seeded whole, split to single pages and merged back to the top");
		if (errors == 0 && backlog == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

>>> buddy_page_allocator.f
rtl/bpa_pkg.sv
rtl/bpa_link_ram.sv
rtl/bpa_pair_ram.sv
rtl/buddy_page_allocator.sv
tb/bpa_checker.sv
tb/buddy_page_allocator_test.sv
